@@ design/cpu16_pkg.sv @@
// Types, opcodes, halt causes and micro-operation codes for the 16-bit execute core.
// Shared by the controller, the datapath and the top level; depends on nothing.
package cpu16_pkg;

    localparam int RAM_BYTES   = 65536;
    localparam int NUM_REGS    = 16;
    localparam int SCREEN_SIDE = 64;

    localparam logic [15:0] SCREEN_BASE = 16'hF000;
    localparam logic [15:0] WORD_TOP    = 16'hFFFF;
    localparam logic [16:0] ROM_MAX     = 17'h10000;

    // item kinds
    localparam logic [1:0] OP_EXEC   = 2'd0;
    localparam logic [1:0] OP_RD_RAM = 2'd1;
    localparam logic [1:0] OP_RD_REG = 2'd2;

    // instruction opcodes
    localparam logic [4:0] OPC_NOP   = 5'd0;
    localparam logic [4:0] OPC_MOV   = 5'd1;
    localparam logic [4:0] OPC_MOVI  = 5'd2;
    localparam logic [4:0] OPC_SWAP  = 5'd3;
    localparam logic [4:0] OPC_LOAD  = 5'd4;
    localparam logic [4:0] OPC_STORE = 5'd5;
    localparam logic [4:0] OPC_STI   = 5'd6;
    localparam logic [4:0] OPC_PUSH  = 5'd7;
    localparam logic [4:0] OPC_POP   = 5'd8;
    localparam logic [4:0] OPC_ADD   = 5'd9;
    localparam logic [4:0] OPC_SUB   = 5'd10;
    localparam logic [4:0] OPC_DIV   = 5'd11;
    localparam logic [4:0] OPC_MUL   = 5'd12;
    localparam logic [4:0] OPC_INC   = 5'd13;
    localparam logic [4:0] OPC_DEC   = 5'd14;
    localparam logic [4:0] OPC_JMP   = 5'd15;
    localparam logic [4:0] OPC_JZ    = 5'd16;
    localparam logic [4:0] OPC_JC    = 5'd17;
    localparam logic [4:0] OPC_JS    = 5'd18;
    localparam logic [4:0] OPC_JO    = 5'd19;
    localparam logic [4:0] OPC_CALL  = 5'd20;
    localparam logic [4:0] OPC_RET   = 5'd21;
    localparam logic [4:0] OPC_AND   = 5'd22;
    localparam logic [4:0] OPC_OR    = 5'd23;
    localparam logic [4:0] OPC_NOT   = 5'd24;
    localparam logic [4:0] OPC_XOR   = 5'd25;
    localparam logic [4:0] OPC_SHL   = 5'd26;
    localparam logic [4:0] OPC_SHR   = 5'd27;
    localparam logic [4:0] OPC_CLS   = 5'd28;
    localparam logic [4:0] OPC_PLOT  = 5'd29;
    localparam logic [4:0] OPC_HALT  = 5'd30;

    // halt causes
    localparam logic [2:0] CAUSE_NONE       = 3'd0;
    localparam logic [2:0] CAUSE_HALT       = 3'd1;
    localparam logic [2:0] CAUSE_BAD_OPC    = 3'd2;
    localparam logic [2:0] CAUSE_PAST_ROM   = 3'd3;
    localparam logic [2:0] CAUSE_STK_EMPTY  = 3'd4;
    localparam logic [2:0] CAUSE_DIV_ZERO   = 3'd5;
    localparam logic [2:0] CAUSE_RAM_TOP    = 3'd6;
    localparam logic [2:0] CAUSE_STK_FULL   = 3'd7;

    // flag bit positions
    localparam int FLAG_Z = 0;
    localparam int FLAG_S = 1;
    localparam int FLAG_C = 2;
    localparam int FLAG_V = 3;

    typedef enum logic [5:0] {
        U_NONE, U_CAPTURE, U_INIT_CLR, U_RD_RAM, U_RD_REG, U_RD_LATCH,
        U_HALT_ROM, U_START, U_GET_A, U_GET_B, U_IMM_A, U_IMM_B, U_IMM_T,
        U_MOV_T, U_WR_RB_A, U_WR_RA_B, U_WR_RA_T, U_LD_HI, U_LD_LO, U_LD_WR,
        U_ST_HI, U_ST_LO, U_PUSH, U_POP, U_POP_WR, U_RET_WR, U_ALU,
        U_DIV_START, U_DIV_STEP, U_DIV_END, U_JUMP, U_CALL, U_CNT_CLR, U_CLS,
        U_PLOT, U_FAULT, U_FINISH, U_OUT
    } t_uop;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] instr_word;
        logic [15:0] imm_first;
        logic [15:0] imm_second;
        logic [15:0] imm_third;
        logic [15:0] read_index;
    } t_in;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [15:0] acc_value;
        logic        zero_flag;
        logic        sign_flag;
        logic        carry_flag;
        logic        overflow_flag;
        logic        halted;
        logic [2:0]  halt_cause;
        logic [15:0] read_data;
    } t_out;

    typedef struct packed {
        logic in_ready;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] opcode;
        logic       ra_zero;
        logic       rb_zero;
        logic       halted;
        logic       past_rom;
        logic       cond_true;
        logic       b_zero;
        logic       init_last;
        logic       scr_last;
        logic       div_last;
        logic       out_busy;
    } t_status;

endpackage

@@ design/cpu16_instruction_execute_core.sv @@
// Top level of the 16-bit instruction execute core.
// Depends on cpu16_pkg, cpu16_ctrl, cpu16_dpath and cpu16_ram.
//
//  channel | direction | handshake                   | beat
//  --------+-----------+-----------------------------+---------------------------------
//  in      | to core   | i_in_valid / o_in_stall     | t_in: op, instruction and three
//          |           |                             | following ROM words, read index
//  out     | from core | o_out_valid / i_out_stall   | t_out: pc, accumulator, flags,
//          |           |                             | halt state, read data
//  cfg     | to core   | i_cfg_valid / o_cfg_ready   | rom_size, 17 bits
//
// Sequencing: a beat is taken only while the sequencer is idle. A read beat passes through
// dispatch, the memory read and the latch before its result is registered. Execute beats
// go straight from dispatch to output when halted or fetching past the ROM; otherwise their
// length is set by the single-port register file (two operand reads) and the byte-wide data
// RAM (a word takes two accesses). Divide adds its start, one-bit-per-cycle loop and write-back
// (no loop on a zero divisor); clear screen adds the one-byte-per-cycle framebuffer sweep.
// Reset: synchronous, active low. After reset a clearing pass writes zero to all 65536 RAM
// bytes, one per cycle; o_in_stall stays high until the pass ends. Config writes are
// always taken.
// Stalls: the result sits in an output register; the next beat is accepted while it waits.
module cpu16_instruction_execute_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cpu16_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cpu16_pkg::t_out  o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [16:0]      i_cfg_data
);
    import cpu16_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: one micro-operation per cycle, holding in its output state while the result register is stalled
    cpu16_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // state, memories, ALU, divider and result register
    cpu16_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // hold the input side whenever the sequencer is busy
    assign o_in_stall  = !cmd.in_ready;
    // the ROM size register takes a write in any cycle
    assign o_cfg_ready = 1'b1;
endmodule

@@ design/cpu16_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the data RAM, the register file and the call stack; no dependencies.
module cpu16_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/cpu16_ctrl.sv @@
// Sequencer of the execute core: walks each item through its micro-operations.
// Depends on cpu16_pkg; talks to cpu16_dpath through t_cmd and t_status.
module cpu16_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  cpu16_pkg::t_status  i_status,
    output cpu16_pkg::t_cmd     o_cmd
);
    import cpu16_pkg::*;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_DISP, S_RDLATCH, S_GETA, S_GETB, S_DEC,
        S_IMMA, S_IMMB, S_IMMT, S_MOVT, S_WRRBA, S_WRRAB, S_WRRAT,
        S_LDHI, S_LDLO, S_LDWR, S_STHI, S_STLO, S_PUSH, S_POP, S_POPWR,
        S_RETWR, S_ALU, S_DIVST, S_DIVSTEP, S_DIVEND, S_JMP, S_CALL,
        S_CLSINIT, S_CLS, S_PLOT, S_FAULT, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_uop   n_uop;
    logic   n_ready;
    logic [4:0] opc;

    assign opc = i_status.opcode;

    always_comb begin
        n_state = r_state;
        n_uop   = U_NONE;
        n_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                n_uop = U_INIT_CLR;
                if (i_status.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                n_ready = 1'b1;
                if (i_in_valid) begin
                    n_uop   = U_CAPTURE;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_status.op)
                    OP_EXEC: begin
                        if (i_status.halted) begin
                            n_state = S_OUT;
                        end else if (i_status.past_rom) begin
                            n_uop   = U_HALT_ROM;
                            n_state = S_OUT;
                        end else begin
                            n_uop   = U_START;
                            n_state = S_GETA;
                        end
                    end
                    OP_RD_RAM: begin
                        n_uop   = U_RD_RAM;
                        n_state = S_RDLATCH;
                    end
                    OP_RD_REG: begin
                        n_uop   = U_RD_REG;
                        n_state = S_RDLATCH;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_RDLATCH: begin
                n_uop   = U_RD_LATCH;
                n_state = S_OUT;
            end
            S_GETA: begin
                n_uop   = U_GET_A;
                n_state = S_GETB;
            end
            S_GETB: begin
                n_uop   = U_GET_B;
                n_state = S_DEC;
            end
            S_DEC: begin
                case (opc)
                    OPC_NOP:  n_state = S_FIN;
                    OPC_MOV:  n_state = S_WRRBA;
                    OPC_MOVI: n_state = S_IMMT;
                    OPC_SWAP: n_state = S_WRRAB;
                    OPC_LOAD, OPC_STORE:
                        n_state = i_status.rb_zero ? S_IMMT : S_MOVT;
                    OPC_STI:  n_state = S_IMMA;
                    OPC_PUSH: n_state = S_PUSH;
                    OPC_POP, OPC_RET: n_state = S_POP;
                    OPC_ADD, OPC_SUB, OPC_MUL:
                        n_state = i_status.rb_zero ? S_IMMB : S_ALU;
                    OPC_DIV:  n_state = i_status.rb_zero ? S_IMMB : S_DIVST;
                    OPC_INC, OPC_DEC, OPC_AND, OPC_OR, OPC_NOT, OPC_XOR,
                    OPC_SHL, OPC_SHR: n_state = S_ALU;
                    OPC_JMP:  n_state = S_JMP;
                    OPC_JZ, OPC_JC, OPC_JS, OPC_JO:
                        n_state = i_status.cond_true ? S_JMP : S_FIN;
                    OPC_CALL: n_state = S_IMMT;
                    OPC_CLS:  n_state = S_CLSINIT;
                    OPC_PLOT: n_state = i_status.ra_zero ? S_IMMA :
                                        (i_status.rb_zero ? S_IMMB : S_IMMT);
                    default:  n_state = S_FAULT;
                endcase
            end
            S_IMMA: begin
                n_uop = U_IMM_A;
                if (opc == OPC_PLOT && i_status.rb_zero) n_state = S_IMMB;
                else n_state = S_IMMT;
            end
            S_IMMB: begin
                n_uop = U_IMM_B;
                case (opc)
                    OPC_DIV:  n_state = S_DIVST;
                    OPC_PLOT: n_state = S_IMMT;
                    default:  n_state = S_ALU;
                endcase
            end
            S_IMMT: begin
                n_uop = U_IMM_T;
                case (opc)
                    OPC_MOVI:           n_state = S_WRRAT;
                    OPC_LOAD:           n_state = S_LDHI;
                    OPC_STORE, OPC_STI: n_state = S_STHI;
                    OPC_CALL:           n_state = S_CALL;
                    default:            n_state = S_PLOT;
                endcase
            end
            S_MOVT: begin
                n_uop   = U_MOV_T;
                n_state = (opc == OPC_LOAD) ? S_LDHI : S_STHI;
            end
            S_WRRAB: begin
                n_uop   = U_WR_RA_B;
                n_state = S_WRRBA;
            end
            S_WRRBA: begin
                n_uop   = U_WR_RB_A;
                n_state = S_FIN;
            end
            S_WRRAT: begin
                n_uop   = U_WR_RA_T;
                n_state = S_FIN;
            end
            S_LDHI: begin
                n_uop   = U_LD_HI;
                n_state = S_LDLO;
            end
            S_LDLO: begin
                n_uop   = U_LD_LO;
                n_state = S_LDWR;
            end
            S_LDWR: begin
                n_uop   = U_LD_WR;
                n_state = S_FIN;
            end
            S_STHI: begin
                n_uop   = U_ST_HI;
                n_state = S_STLO;
            end
            S_STLO: begin
                n_uop   = U_ST_LO;
                n_state = S_FIN;
            end
            S_PUSH: begin
                n_uop   = U_PUSH;
                n_state = S_FIN;
            end
            S_POP: begin
                n_uop   = U_POP;
                n_state = (opc == OPC_RET) ? S_RETWR : S_POPWR;
            end
            S_POPWR: begin
                n_uop   = U_POP_WR;
                n_state = S_FIN;
            end
            S_RETWR: begin
                n_uop   = U_RET_WR;
                n_state = S_FIN;
            end
            S_ALU: begin
                n_uop   = U_ALU;
                n_state = S_FIN;
            end
            S_DIVST: begin
                n_uop   = U_DIV_START;
                n_state = i_status.b_zero ? S_FIN : S_DIVSTEP;
            end
            S_DIVSTEP: begin
                n_uop = U_DIV_STEP;
                if (i_status.div_last) n_state = S_DIVEND;
            end
            S_DIVEND: begin
                n_uop   = U_DIV_END;
                n_state = S_FIN;
            end
            S_JMP: begin
                n_uop   = U_JUMP;
                n_state = S_FIN;
            end
            S_CALL: begin
                n_uop   = U_CALL;
                n_state = S_FIN;
            end
            S_CLSINIT: begin
                n_uop   = U_CNT_CLR;
                n_state = S_CLS;
            end
            S_CLS: begin
                n_uop = U_CLS;
                if (i_status.scr_last) n_state = S_FIN;
            end
            S_PLOT: begin
                n_uop   = U_PLOT;
                n_state = S_FIN;
            end
            S_FAULT: begin
                n_uop   = U_FAULT;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_uop   = U_FINISH;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    n_uop   = U_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.in_ready = n_ready;
    assign o_cmd.uop      = n_uop;
endmodule

@@ design/cpu16_dpath.sv @@
// Datapath of the execute core: architectural state, ALU, divider, memories, result register.
// Depends on cpu16_pkg and cpu16_ram; driven by micro-operations from cpu16_ctrl.
module cpu16_dpath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpu16_pkg::t_cmd     i_cmd,
    output cpu16_pkg::t_status  o_status,
    input  cpu16_pkg::t_in      i_in_data,
    input  logic                i_cfg_we,
    input  logic [16:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cpu16_pkg::t_out     o_out_data
);
    import cpu16_pkg::*;

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    t_in         r_item;
    t_out        r_out;
    logic        r_ovalid;
    logic [16:0] r_rom;
    logic [15:0] r_pc, r_acc, r_start_pc;
    logic [3:0]  r_flags;
    logic        r_halted;
    logic [2:0]  r_cause, r_fault;
    logic [1:0]  r_k;
    logic        r_jumped, r_ok;
    logic [15:0] r_a, r_b, r_t, r_w, r_rd, r_cnt;
    logic [PW-1:0] r_sp;
    logic [NUM_REGS-1:0] r_rv;
    logic        r_rvq;

    t_uop        uop;
    logic [4:0]  opc;
    logic [3:0]  ra, rb;
    logic [16:0] rom_limit;

    assign uop = i_cmd.uop;
    assign opc = r_item.instr_word[15:11];
    assign ra  = r_item.instr_word[10:7];
    assign rb  = r_item.instr_word[6:3];
    assign rom_limit = r_rom[16] ? ROM_MAX : r_rom;

    // immediate fetch: word k after the instruction
    logic [15:0] imm_word, imm_val;
    logic [16:0] imm_addr;
    logic        imm_bad;
    always_comb begin
        case (r_k)
            2'd0:    imm_word = r_item.imm_first;
            2'd1:    imm_word = r_item.imm_second;
            default: imm_word = r_item.imm_third;
        endcase
        imm_addr = {1'b0, r_start_pc} + {14'd0, r_k, 1'b0} + 17'd3;
        imm_bad  = imm_addr >= rom_limit;
        imm_val  = imm_bad ? 16'd0 : imm_word;
    end

    // register file
    logic                        rf_we;
    logic [$clog2(NUM_REGS)-1:0] rf_waddr, rf_raddr;
    logic [15:0]                 rf_wdata, rf_q, reg_val;

    // data RAM
    logic        dm_we;
    logic [15:0] dm_waddr, dm_raddr;
    logic [7:0]  dm_wdata, dm_q;

    // call stack
    logic          st_we;
    logic [SW-1:0] st_waddr, st_raddr;
    logic [15:0]   st_wdata, st_q;
    logic          st_full, st_empty;
    logic [PW-1:0] sp_dec;

    assign reg_val  = r_rvq ? rf_q : 16'd0;
    assign st_full  = r_sp >= PW'(STACK_DEPTH);
    assign st_empty = r_sp == '0;
    assign sp_dec   = r_sp - 1'b1;

    logic addr_top;
    logic [15:0] t_inc;
    assign addr_top = r_t == WORD_TOP;
    assign t_inc    = r_t + 16'd1;

    // ALU
    logic [16:0] sum17;
    logic [31:0] prod;
    logic [15:0] alu_res;
    logic        alu_c, alu_v;
    always_comb begin
        sum17   = {1'b0, r_a} + {1'b0, r_b};
        prod    = r_a * r_b;
        alu_res = 16'd0;
        alu_c   = 1'b0;
        alu_v   = 1'b0;
        case (opc)
            OPC_ADD: begin
                alu_res = sum17[15:0];
                alu_c   = sum17[16];
                alu_v   = ~(r_a[15] ^ r_b[15]) & (r_a[15] ^ alu_res[15]);
            end
            OPC_SUB: begin
                alu_res = r_a - r_b;
                alu_c   = r_a < r_b;
                alu_v   = (r_a[15] ^ r_b[15]) & (r_a[15] ^ alu_res[15]);
            end
            OPC_MUL: begin
                alu_res = prod[15:0];
                alu_c   = |prod[31:16];
            end
            OPC_INC: begin
                alu_res = r_a + 16'd1;
                alu_c   = alu_res == 16'h0000;
                alu_v   = alu_res == 16'h8000;
            end
            OPC_DEC: begin
                alu_res = r_a - 16'd1;
                alu_c   = alu_res == 16'hFFFF;
                alu_v   = alu_res == 16'h7FFF;
            end
            OPC_AND: alu_res = r_a & r_b;
            OPC_OR:  alu_res = r_a | r_b;
            OPC_NOT: alu_res = ~r_a;
            OPC_XOR: alu_res = r_a ^ r_b;
            OPC_SHL: begin
                alu_res = {r_a[14:0], 1'b0};
                alu_c   = r_a[15];
            end
            OPC_SHR: begin
                alu_res = {1'b0, r_a[15:1]};
                alu_c   = r_a[0];
            end
            default: alu_res = 16'd0;
        endcase
    end

    // one restoring divide step: remainder in r_t, quotient shifts through r_w
    logic [16:0] div_sh;
    logic        div_ge;
    logic [16:0] div_rem;
    assign div_sh  = {r_t, r_w[15]};
    assign div_ge  = div_sh >= {1'b0, r_b};
    assign div_rem = div_ge ? (div_sh - {1'b0, r_b}) : div_sh;

    logic cond_true;
    always_comb begin
        case (opc)
            OPC_JZ:  cond_true = r_flags[FLAG_Z];
            OPC_JC:  cond_true = r_flags[FLAG_C];
            OPC_JS:  cond_true = r_flags[FLAG_S];
            OPC_JO:  cond_true = r_flags[FLAG_V];
            default: cond_true = 1'b0;
        endcase
    end

    logic plot_on;
    assign plot_on = (r_a[15:6] == 10'd0) && (r_b[15:6] == 10'd0);

    // memory port steering and fault code of this micro-operation
    logic [2:0] n_fault_code;
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = ra;
        rf_wdata = alu_res;
        rf_raddr = ra;
        dm_we    = 1'b0;
        dm_waddr = r_t;
        dm_wdata = r_a[15:8];
        dm_raddr = r_t;
        st_we    = 1'b0;
        st_waddr = r_sp[SW-1:0];
        st_wdata = r_a;
        st_raddr = sp_dec[SW-1:0];
        n_fault_code = CAUSE_NONE;
        case (uop)
            U_INIT_CLR: begin
                dm_we    = 1'b1;
                dm_waddr = r_cnt;
                dm_wdata = 8'd0;
            end
            U_CLS: begin
                dm_we    = 1'b1;
                dm_waddr = {SCREEN_BASE[15:12], r_cnt[11:0]};
                dm_wdata = 8'd0;
            end
            U_RD_RAM: dm_raddr = r_item.read_index;
            U_RD_REG: rf_raddr = r_item.read_index[3:0];
            U_GET_A:  rf_raddr = rb;
            U_IMM_A, U_IMM_B, U_IMM_T, U_JUMP:
                if (imm_bad) n_fault_code = CAUSE_PAST_ROM;
            U_WR_RB_A: begin
                rf_we    = 1'b1;
                rf_waddr = rb;
                rf_wdata = r_a;
            end
            U_WR_RA_B: begin
                rf_we    = 1'b1;
                rf_wdata = r_b;
            end
            U_WR_RA_T: begin
                rf_we    = 1'b1;
                rf_wdata = r_t;
            end
            U_LD_HI: if (addr_top) n_fault_code = CAUSE_RAM_TOP;
            U_LD_LO: dm_raddr = t_inc;
            U_LD_WR: begin
                rf_we    = 1'b1;
                rf_wdata = addr_top ? 16'd0 : {r_w[15:8], dm_q};
            end
            U_ST_HI: begin
                dm_we = !addr_top;
                if (addr_top) n_fault_code = CAUSE_RAM_TOP;
            end
            U_ST_LO: begin
                dm_we    = !addr_top;
                dm_waddr = t_inc;
                dm_wdata = r_a[7:0];
            end
            U_PUSH: begin
                st_we = !st_full;
                if (st_full) n_fault_code = CAUSE_STK_FULL;
            end
            U_CALL: begin
                st_we    = !st_full;
                st_wdata = r_pc + 16'd2;
                if (st_full) n_fault_code = CAUSE_STK_FULL;
            end
            U_POP: if (st_empty) n_fault_code = CAUSE_STK_EMPTY;
            U_POP_WR: begin
                rf_we    = r_ok;
                rf_wdata = st_q;
            end
            U_ALU: rf_we = 1'b1;
            U_DIV_START: if (r_b == 16'd0) n_fault_code = CAUSE_DIV_ZERO;
            U_DIV_END: begin
                rf_we    = 1'b1;
                rf_wdata = r_w;
            end
            U_PLOT: begin
                dm_we    = plot_on;
                dm_waddr = {SCREEN_BASE[15:12], r_b[5:0], r_a[5:0]};
                dm_wdata = r_t[7:0];
            end
            U_FAULT: n_fault_code = (opc == OPC_HALT) ? CAUSE_HALT : CAUSE_BAD_OPC;
            default: n_fault_code = CAUSE_NONE;
        endcase
    end

    cpu16_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_regs (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(rf_raddr), .o_rdata(rf_q)
    );

    cpu16_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_dram (
        .i_clk(i_clk), .i_we(dm_we), .i_waddr(dm_waddr), .i_wdata(dm_wdata),
        .i_raddr(dm_raddr), .o_rdata(dm_q)
    );

    cpu16_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_q)
    );

    // flags after an ALU result
    logic [3:0] alu_flags;
    assign alu_flags = {alu_v, alu_c, alu_res[15], alu_res == 16'd0};

    always_ff @(posedge i_clk) begin
        r_rvq <= r_rv[rf_raddr];
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_rom    <= 17'd0;
            r_pc     <= 16'd0;
            r_acc    <= 16'd0;
            r_flags  <= 4'd0;
            r_halted <= 1'b0;
            r_cause  <= CAUSE_NONE;
            r_fault  <= CAUSE_NONE;
            r_k      <= 2'd0;
            r_jumped <= 1'b0;
            r_ok     <= 1'b0;
            r_cnt    <= 16'd0;
            r_sp     <= '0;
            r_rv     <= '0;
        end else begin
            if (i_cfg_we) r_rom <= i_cfg_data;
            if (rf_we) r_rv[rf_waddr] <= 1'b1;
            if (r_fault == CAUSE_NONE && n_fault_code != CAUSE_NONE) begin
                r_fault <= n_fault_code;
            end
            // load a fresh result, or drop the one just taken
            if (uop == U_OUT) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;

            case (uop)
                U_CAPTURE: begin
                    r_item <= i_in_data;
                    r_rd   <= 16'd0;
                end
                U_INIT_CLR, U_CLS: r_cnt <= r_cnt + 16'd1;
                U_CNT_CLR: r_cnt <= 16'd0;
                U_RD_LATCH: begin
                    if (r_item.op == OP_RD_RAM) r_rd <= {8'd0, dm_q};
                    else r_rd <= (r_item.read_index[15:4] == 12'd0) ? reg_val : 16'd0;
                end
                U_HALT_ROM: begin
                    r_halted <= 1'b1;
                    r_cause  <= CAUSE_PAST_ROM;
                end
                U_START: begin
                    r_fault    <= CAUSE_NONE;
                    r_k        <= 2'd0;
                    r_start_pc <= r_pc;
                    r_jumped   <= 1'b0;
                end
                U_GET_A: r_a <= reg_val;
                U_GET_B: r_b <= reg_val;
                U_IMM_A, U_IMM_B, U_IMM_T: begin
                    r_k  <= r_k + 2'd1;
                    r_pc <= r_pc + 16'd2;
                    if (uop == U_IMM_A) r_a <= imm_val;
                    else if (uop == U_IMM_B) r_b <= imm_val;
                    else r_t <= imm_val;
                end
                U_MOV_T: r_t <= r_b;
                U_LD_LO: r_w <= {dm_q, 8'd0};
                U_PUSH: if (!st_full) r_sp <= r_sp + 1'b1;
                U_POP: begin
                    r_ok <= !st_empty;
                    if (!st_empty) r_sp <= sp_dec;
                end
                U_RET_WR: begin
                    if (r_ok) begin
                        r_pc     <= st_q;
                        r_jumped <= 1'b1;
                    end
                end
                U_ALU: begin
                    r_acc   <= alu_res;
                    r_flags <= alu_flags;
                end
                U_DIV_START: begin
                    r_t   <= 16'd0;
                    r_w   <= r_a;
                    r_cnt <= 16'd0;
                end
                U_DIV_STEP: begin
                    r_t   <= div_rem[15:0];
                    r_w   <= {r_w[14:0], div_ge};
                    r_cnt <= r_cnt + 16'd1;
                end
                U_DIV_END: begin
                    r_acc   <= r_w;
                    r_flags <= {2'b00, r_w[15], r_w == 16'd0};
                end
                U_JUMP: begin
                    r_k      <= r_k + 2'd1;
                    r_pc     <= imm_val;
                    r_jumped <= 1'b1;
                    case (opc)
                        OPC_JZ:  r_flags[FLAG_Z] <= 1'b0;
                        OPC_JC:  r_flags[FLAG_C] <= 1'b0;
                        OPC_JS:  r_flags[FLAG_S] <= 1'b0;
                        OPC_JO:  r_flags[FLAG_V] <= 1'b0;
                        default: r_flags <= r_flags;
                    endcase
                end
                U_CALL: begin
                    if (!st_full) r_sp <= r_sp + 1'b1;
                    r_pc     <= r_t;
                    r_jumped <= 1'b1;
                end
                U_FINISH: begin
                    if (!r_jumped) r_pc <= r_pc + 16'd2;
                    if (r_fault != CAUSE_NONE) begin
                        r_halted <= 1'b1;
                        r_cause  <= r_fault;
                    end
                end
                U_OUT: begin
                    r_out    <= '{next_pc: r_pc, acc_value: r_acc,
                                  zero_flag: r_flags[FLAG_Z], sign_flag: r_flags[FLAG_S],
                                  carry_flag: r_flags[FLAG_C],
                                  overflow_flag: r_flags[FLAG_V],
                                  halted: r_halted, halt_cause: r_cause, read_data: r_rd};
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_status.op        = r_item.op;
    assign o_status.opcode    = opc;
    assign o_status.ra_zero   = ra == 4'd0;
    assign o_status.rb_zero   = rb == 4'd0;
    assign o_status.halted    = r_halted;
    assign o_status.past_rom  = ({1'b0, r_pc} + 17'd1) >= rom_limit;
    assign o_status.cond_true = cond_true;
    assign o_status.b_zero    = r_b == 16'd0;
    assign o_status.init_last = r_cnt == 16'hFFFF;
    assign o_status.scr_last  = r_cnt[11:0] == 12'hFFF;
    assign o_status.div_last  = r_cnt[3:0] == 4'hF;
    assign o_status.out_busy  = r_ovalid & i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    a_halt_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_cause != CAUSE_NONE)
        else $error("halted without a cause");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_halted))
        else $error("halt released");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop == U_OUT) |-> !(r_ovalid && i_out_stall))
        else $error("result register overwritten while stalled");
endmodule
